@@ src/bwt_pkg.sv @@
// Shared types and constants for the barycentric weight unit.
// Depends on nothing; used by barycentric_weights_3d_inside_test.
`timescale 1ns / 1ps
package bwt_pkg;
	localparam logic [1:0] ST_INSIDE     = 2'd0;
	localparam logic [1:0] ST_DEGENERATE = 2'd1;
	localparam logic [1:0] ST_OUTSIDE    = 2'd2;

	localparam logic REG_DEGEN_LIMIT = 1'b0;
	localparam logic REG_NEG_TOL     = 1'b1;
endpackage

@@ src/bwt_div_cell.sv @@
// One restoring-division cell: one quotient bit per stage for two dividends.
// Depends on nothing else; chained by barycentric_weights_3d_inside_test.
`timescale 1ns / 1ps
module bwt_div_cell #(
	parameter int DW = 8,
	parameter int QW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_in,
	input  logic [DW-1:0] den_in,
	input  logic [DW:0]   r1_in,
	input  logic [DW:0]   r2_in,
	input  logic [QW-1:0] q1_in,
	input  logic [QW-1:0] q2_in,
	input  logic [DW-1:0] n1_in,
	input  logic [DW-1:0] n2_in,
	output logic [DW-1:0] den_out,
	output logic [DW:0]   r1_out,
	output logic [DW:0]   r2_out,
	output logic [QW-1:0] q1_out,
	output logic [QW-1:0] q2_out,
	output logic [DW-1:0] n1_out,
	output logic [DW-1:0] n2_out,
	output logic          v_out
);
	logic [DW+1:0] t1, t2;
	logic [DW+1:0] d_ext;
	logic ge1, ge2;

	always_comb begin
		d_ext = {2'b00, den_in};
		t1 = {r1_in, n1_in[DW-1]};
		t2 = {r2_in, n2_in[DW-1]};
		ge1 = t1 >= d_ext;
		ge2 = t2 >= d_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_out <= 1'b0;
		else v_out <= v_in;
	end

	always_ff @(posedge clk) begin
		den_out <= den_in;
		r1_out <= ge1 ? (DW+1)'(t1 - d_ext) : t1[DW:0];
		r2_out <= ge2 ? (DW+1)'(t2 - d_ext) : t2[DW:0];
		q1_out <= {q1_in[QW-2:0], ge1};
		q2_out <= {q2_in[QW-2:0], ge2};
		n1_out <= {n1_in[DW-2:0], 1'b0};
		n2_out <= {n2_in[DW-2:0], 1'b0};
	end
endmodule

@@ src/barycentric_weights_3d_inside_test.sv @@
// Top level: barycentric weights of a point against a 3D triangle.
// Depends on bwt_pkg and bwt_div_cell.
`timescale 1ns / 1ps
//
//  channel   | signals                                   | transfer when
//  ----------+-------------------------------------------+-----------------------
//  command   | start, busy, a_*, b_*, c_*, pt_*          | start && !busy
//  result    | done, status, weight_edge_one/two, _rest  | done (one cycle)
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One command per cycle; busy is held low. The path from the transfer edge to
// done runs through four front stages (differences, dot products,
// full-width products, determinant and numerators), WEIGHT_FRAC_BITS+3
// division cells, one quotient bit per cell, then a sign/saturate/classify stage.
// Reset clears the valid pipe and sets the config registers to their reset values.
// The receiver cannot stall: each result is shown for exactly one cycle.
module barycentric_weights_3d_inside_test #(
	parameter int COORD_BITS = 12,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [COORD_BITS-1:0] a_x, a_y, a_z,
	input  logic signed [COORD_BITS-1:0] b_x, b_y, b_z,
	input  logic signed [COORD_BITS-1:0] c_x, c_y, c_z,
	input  logic signed [COORD_BITS-1:0] pt_x, pt_y, pt_z,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [31:0] cfg_data,
	output logic done,
	output logic [1:0] status,
	output logic signed [WEIGHT_FRAC_BITS+1:0] weight_edge_one,
	output logic signed [WEIGHT_FRAC_BITS+1:0] weight_edge_two,
	output logic signed [WEIGHT_FRAC_BITS+1:0] weight_rest
);
	localparam int EW = COORD_BITS + 1;          // edge width
	localparam int PW = 2 * EW + 2;              // dot product width
	localparam int GW = 2 * PW + 1;              // determinant / numerator width
	localparam int WW = WEIGHT_FRAC_BITS + 2;    // weight width
	localparam int QW = WEIGHT_FRAC_BITS + 3;    // integer bits + fraction
	localparam int NC = QW;                      // division cells
	localparam int DW = GW;

	logic [31:0] limit_q;
	logic [15:0] tol_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 32'd1;
			tol_q <= 16'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bwt_pkg::REG_DEGEN_LIMIT: limit_q <= cfg_data;
				bwt_pkg::REG_NEG_TOL:     tol_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// stage 1: edges and offset
	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3], q_s1 [3];
	logic v_s1, v_s2, v_s3, v_s4;
	always_ff @(posedge clk) begin
		e1_s1[0] <= EW'(b_x) - EW'(a_x);
		e1_s1[1] <= EW'(b_y) - EW'(a_y);
		e1_s1[2] <= EW'(b_z) - EW'(a_z);
		e2_s1[0] <= EW'(c_x) - EW'(a_x);
		e2_s1[1] <= EW'(c_y) - EW'(a_y);
		e2_s1[2] <= EW'(c_z) - EW'(a_z);
		q_s1[0] <= EW'(pt_x) - EW'(a_x);
		q_s1[1] <= EW'(pt_y) - EW'(a_y);
		q_s1[2] <= EW'(pt_z) - EW'(a_z);
	end

	// stage 2: five dot products
	logic signed [PW-1:0] d11_s2, d12_s2, d22_s2, dq1_s2, dq2_s2;
	function automatic logic signed [PW-1:0] dot3(input logic signed [EW-1:0] x [3],
		input logic signed [EW-1:0] y [3]);
		dot3 = PW'(x[0] * y[0]) + PW'(x[1] * y[1]) + PW'(x[2] * y[2]);
	endfunction
	always_ff @(posedge clk) begin
		d11_s2 <= dot3(e1_s1, e1_s1);
		d12_s2 <= dot3(e1_s1, e2_s1);
		d22_s2 <= dot3(e2_s1, e2_s1);
		dq1_s2 <= dot3(q_s1, e1_s1);
		dq2_s2 <= dot3(q_s1, e2_s1);
	end

	// stage 3: six products
	logic signed [GW-1:0] p_a_s3, p_b_s3, p_c_s3, p_d_s3, p_e_s3, p_f_s3;
	always_ff @(posedge clk) begin
		p_a_s3 <= GW'(d11_s2 * d22_s2);
		p_b_s3 <= GW'(d12_s2 * d12_s2);
		p_c_s3 <= GW'(d22_s2 * dq1_s2);
		p_d_s3 <= GW'(d12_s2 * dq2_s2);
		p_e_s3 <= GW'(d11_s2 * dq2_s2);
		p_f_s3 <= GW'(d12_s2 * dq1_s2);
	end

	// stage 4: determinant and numerators, magnitudes and signs
	logic signed [GW-1:0] den_c, n1_c, n2_c;
	logic [DW-1:0] dmag_s4, n1m_s4, n2m_s4;
	logic neg1_s4, neg2_s4, degen_s4;
	always_comb begin
		den_c = p_a_s3 - p_b_s3;
		n1_c = p_c_s3 - p_d_s3;
		n2_c = p_e_s3 - p_f_s3;
		if (den_c[GW-1]) begin
			n1_c = -n1_c;
			n2_c = -n2_c;
		end
	end
	always_ff @(posedge clk) begin
		dmag_s4 <= den_c[GW-1] ? DW'(-den_c) : DW'(den_c);
		neg1_s4 <= n1_c[GW-1];
		neg2_s4 <= n2_c[GW-1];
		n1m_s4 <= n1_c[GW-1] ? DW'(-n1_c) : DW'(n1_c);
		n2m_s4 <= n2_c[GW-1] ? DW'(-n2_c) : DW'(n2_c);
		degen_s4 <= (den_c == '0) ||
			((den_c[GW-1] ? DW'(-den_c) : DW'(den_c)) < DW'(limit_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= start; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	// division chain: quotient of (n << F) / den. Over-range (n >= 4*den) is
	// caught by a flag. Otherwise n >> 3 < den, so the chain starts with that
	// remainder and takes n[2], n[1], n[0], then F zeros: QW = F+3 bits.
	logic [DW:0] r_init1, r_init2;
	logic [DW-1:0] f1, f2;
	logic ovr1_s4, ovr2_s4;
	always_comb begin
		r_init1 = {4'b0000, n1m_s4[DW-1:3]};
		r_init2 = {4'b0000, n2m_s4[DW-1:3]};
		f1 = {n1m_s4[2:0], {(DW-3){1'b0}}};
		f2 = {n2m_s4[2:0], {(DW-3){1'b0}}};
		ovr1_s4 = {2'b00, n1m_s4} >= {dmag_s4, 2'b00};
		ovr2_s4 = {2'b00, n2m_s4} >= {dmag_s4, 2'b00};
	end

	typedef struct packed {
		logic neg1, neg2, ovr1, ovr2, degen;
	} side_t;

	logic [DW-1:0] c_den [NC+1];
	logic [DW:0]   c_r1 [NC+1], c_r2 [NC+1];
	logic [QW-1:0] c_q1 [NC+1], c_q2 [NC+1];
	logic [DW-1:0] c_n1 [NC+1], c_n2 [NC+1];
	logic          c_v [NC+1];
	side_t         c_sd [NC+1];

	assign c_den[0] = dmag_s4;
	assign c_r1[0] = r_init1;
	assign c_r2[0] = r_init2;
	assign c_q1[0] = '0;
	assign c_q2[0] = '0;
	assign c_n1[0] = f1;
	assign c_n2[0] = f2;
	assign c_v[0] = v_s4;
	assign c_sd[0] = '{neg1: neg1_s4, neg2: neg2_s4, ovr1: ovr1_s4, ovr2: ovr2_s4,
		degen: degen_s4};

	for (genvar g = 0; g < NC; g++) begin : g_cell
		bwt_div_cell #(.DW(DW), .QW(QW)) u_cell (
			.clk(clk), .arst_n(arst_n), .v_in(c_v[g]), .den_in(c_den[g]),
			.r1_in(c_r1[g]), .r2_in(c_r2[g]), .q1_in(c_q1[g]), .q2_in(c_q2[g]),
			.n1_in(c_n1[g]), .n2_in(c_n2[g]),
			.den_out(c_den[g+1]), .r1_out(c_r1[g+1]), .r2_out(c_r2[g+1]),
			.q1_out(c_q1[g+1]), .q2_out(c_q2[g+1]),
			.n1_out(c_n1[g+1]), .n2_out(c_n2[g+1]), .v_out(c_v[g+1])
		);
		always_ff @(posedge clk) c_sd[g+1] <= c_sd[g];
	end

	// Final: sign, saturate, rest weight, classify
	localparam logic signed [WW+1:0] WMAX = (WW+2)'((1 <<< (WW-1)) - 1);
	localparam logic signed [WW+1:0] WMIN = -(WW+2)'(1 <<< (WW-1));
	localparam logic signed [WW+1:0] ONE  = (WW+2)'(1 <<< WEIGHT_FRAC_BITS);

	function automatic logic signed [WW+1:0] sat(input logic signed [WW+1:0] v);
		sat = (v > WMAX) ? WMAX : ((v < WMIN) ? WMIN : v);
	endfunction

	logic signed [WW+1:0] m1, m2, w1, w2, wr, ntol;
	side_t sd;
	logic out_c;
	always_comb begin
		sd = c_sd[NC];
		m1 = sd.ovr1 ? (WW+2)'(1 <<< WW) : (WW+2)'(c_q1[NC]);
		m2 = sd.ovr2 ? (WW+2)'(1 <<< WW) : (WW+2)'(c_q2[NC]);
		w1 = sat(sd.neg1 ? -m1 : m1);
		w2 = sat(sd.neg2 ? -m2 : m2);
		wr = sat(ONE - w1 - w2);
		ntol = -(WW+2)'(tol_q);
		out_c = (w1 < ntol) || (w2 < ntol) || (wr < ntol);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= c_v[NC];
	end

	always_ff @(posedge clk) begin
		if (sd.degen) begin
			status <= bwt_pkg::ST_DEGENERATE;
			weight_edge_one <= '0; weight_edge_two <= '0; weight_rest <= '0;
		end else if (out_c) begin
			status <= bwt_pkg::ST_OUTSIDE;
			weight_edge_one <= '0; weight_edge_two <= '0; weight_rest <= '0;
		end else begin
			status <= bwt_pkg::ST_INSIDE;
			weight_edge_one <= WW'(w1);
			weight_edge_two <= WW'(w2);
			weight_rest <= WW'(wr);
		end
	end

	a_busy_low: assert property (@(posedge clk) busy == 1'b0)
		else $error("busy raised");
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(c_v[NC])) else $error("done without item");
	a_zero_when_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != bwt_pkg::ST_INSIDE) |-> (weight_edge_one == '0 &&
		weight_edge_two == '0 && weight_rest == '0)) else $error("nonzero weights");
endmodule
